// ===== rtl/core/sed_pkg.sv =====
// Shared types and constants for the string escape decoder.
package sed_pkg;

  localparam int IN_DEPTH_DEF  = 4;
  localparam int OUT_DEPTH_DEF = 2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_WARN    = 2'd1;
  localparam logic [1:0] ST_ILLEGAL = 2'd2;
  localparam logic [1:0] ST_SHORT   = 2'd3;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  typedef enum logic [1:0] {
    ESC_CODE = 2'd0,
    ESC_U    = 2'd1,
    ESC_ZERO = 2'd2,
    ESC_BAD  = 2'd3
  } esc_kind_t;

  // Classified input word handed from front to back.
  typedef struct packed {
    logic [7:0] ch;
    logic       warn;
    logic       last;
    logic       is_bslash;
    esc_kind_t  esc_kind;
    logic [7:0] esc_code;
    logic       hex_ok;
    logic [3:0] hex_digit;
  } sed_class_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic [1:0]  status;
    logic        end_of_string;
  } sed_result_t;

endpackage

// ===== rtl/core/sed_fifo.sv =====
// Small register-based first-in first-out queue.
module sed_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == FULL_CNT);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/sed_front.sv =====
// Front end: mode register, byte masking and character classification.
module sed_front import sed_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic [7:0] char_byte,
  input  logic       is_last,
  output sed_class_t cls
);

  logic       legacy_mode;
  logic [7:0] mc;
  logic       warn;

  always_ff @(posedge clk) begin
    if (rst) begin
      legacy_mode <= 1'b0;
    end else if (cfg_we) begin
      legacy_mode <= cfg_wdata;
    end
  end

  // Replace non-ASCII bytes by a space unless in legacy mode.
  assign warn = !legacy_mode && char_byte[7];
  assign mc   = warn ? CH_SPACE : char_byte;

  always_comb begin
    cls           = '0;
    cls.ch        = mc;
    cls.warn      = warn;
    cls.last      = is_last;
    cls.is_bslash = (mc == CH_BSLASH);

    unique case (mc)
      8'h61: begin cls.esc_kind = ESC_CODE; cls.esc_code = 8'h07; end // a
      8'h62: begin cls.esc_kind = ESC_CODE; cls.esc_code = 8'h08; end // b
      8'h66: begin cls.esc_kind = ESC_CODE; cls.esc_code = 8'h0C; end // f
      8'h6E: begin cls.esc_kind = ESC_CODE; cls.esc_code = 8'h0A; end // n
      8'h72: begin cls.esc_kind = ESC_CODE; cls.esc_code = 8'h0D; end // r
      8'h74: begin cls.esc_kind = ESC_CODE; cls.esc_code = 8'h09; end // t
      8'h76: begin cls.esc_kind = ESC_CODE; cls.esc_code = 8'h0B; end // v
      8'h27, 8'h22, CH_BSLASH: begin
        cls.esc_kind = ESC_CODE;
        cls.esc_code = mc;
      end
      8'h75:   cls.esc_kind = ESC_U;
      8'h00:   cls.esc_kind = ESC_ZERO;
      default: cls.esc_kind = ESC_BAD;
    endcase

    if (mc >= 8'h30 && mc <= 8'h39) begin
      cls.hex_ok    = 1'b1;
      cls.hex_digit = mc[3:0];
    end else if ((mc >= 8'h61 && mc <= 8'h66) || (mc >= 8'h41 && mc <= 8'h46)) begin
      cls.hex_ok    = 1'b1;
      cls.hex_digit = 4'(mc[3:0] + 4'd9);
    end
  end

endmodule

// ===== rtl/core/sed_back.sv =====
// Back end: escape state machine that turns classified words into results.
module sed_back import sed_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  sed_class_t  cls,
  input  logic        in_valid,
  output logic        take,
  input  logic        out_full,
  output logic        res_push,
  output sed_result_t res
);

  typedef enum logic [3:0] {
    PH_NORMAL = 4'b0001,
    PH_ESCAPE = 4'b0010,
    PH_HEX    = 4'b0100,
    PH_DROP   = 4'b1000
  } phase_t;

  phase_t      phase, phase_next;
  logic [1:0]  hex_count, hex_count_next;
  logic [15:0] hex_value, hex_value_next;
  logic        hex_stopped, hex_stopped_next;
  logic [15:0] shifted;
  logic        digit_in;
  logic [1:0]  ok;

  assign take     = in_valid && !out_full;
  assign ok       = cls.warn ? ST_WARN : ST_OK;
  assign digit_in = !hex_stopped && cls.hex_ok;
  assign shifted  = digit_in ? {hex_value[11:0], cls.hex_digit} : hex_value;

  always_comb begin
    phase_next       = phase;
    hex_count_next   = hex_count;
    hex_value_next   = hex_value;
    hex_stopped_next = hex_stopped;
    res_push         = 1'b0;
    res              = '0;

    if (take) begin
      unique case (phase)
        PH_NORMAL: begin
          if (cls.is_bslash) begin
            if (cls.last) begin
              res_push = 1'b1;
              res      = '{16'd0, ST_SHORT, 1'b1};
            end else begin
              phase_next = PH_ESCAPE;
            end
          end else begin
            res_push = 1'b1;
            res      = '{{8'd0, cls.ch}, ok, cls.last};
          end
        end

        PH_ESCAPE: begin
          phase_next = PH_NORMAL;
          unique case (cls.esc_kind)
            ESC_CODE: begin
              res_push = 1'b1;
              res      = '{{8'd0, cls.esc_code}, ok, cls.last};
            end
            ESC_U: begin
              if (cls.last) begin
                res_push = 1'b1;
                res      = '{16'd0, ST_SHORT, 1'b1};
              end else begin
                phase_next       = PH_HEX;
                hex_count_next   = '0;
                hex_value_next   = '0;
                hex_stopped_next = 1'b0;
              end
            end
            ESC_ZERO: begin
              phase_next = cls.last ? PH_NORMAL : PH_DROP;
              res_push   = 1'b1;
              res        = '{16'd0, ST_SHORT, 1'b1};
            end
            default: begin
              phase_next = cls.last ? PH_NORMAL : PH_DROP;
              res_push   = 1'b1;
              res        = '{16'd0, ST_ILLEGAL, 1'b1};
            end
          endcase
        end

        PH_HEX: begin
          if (hex_count == 2'd3) begin
            // Fourth character: give the value and clear.
            phase_next       = PH_NORMAL;
            hex_count_next   = '0;
            hex_value_next   = '0;
            hex_stopped_next = 1'b0;
            res_push         = 1'b1;
            res              = '{shifted, ok, cls.last};
          end else if (cls.last) begin
            phase_next       = PH_NORMAL;
            hex_count_next   = '0;
            hex_value_next   = '0;
            hex_stopped_next = 1'b0;
            res_push         = 1'b1;
            res              = '{16'd0, ST_SHORT, 1'b1};
          end else begin
            hex_count_next   = hex_count + 2'd1;
            hex_value_next   = shifted;
            hex_stopped_next = !digit_in;
          end
        end

        PH_DROP: begin
          // Drop until the last word of the string.
          if (cls.last) begin
            phase_next = PH_NORMAL;
          end
        end

        default: begin
          phase_next = PH_NORMAL;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_NORMAL;
      hex_count   <= '0;
      hex_value   <= '0;
      hex_stopped <= 1'b0;
    end else begin
      phase       <= phase_next;
      hex_count   <= hex_count_next;
      hex_value   <= hex_value_next;
      hex_stopped <= hex_stopped_next;
    end
  end

endmodule

// ===== rtl/core/string_escape_decoder_core.sv =====
// String escape decoder: byte stream in, 16-bit code units out.
//
// Input queue: drive char_byte/is_last and raise push; a word is taken at
// a clock edge with push high and full low. Result queue: while empty is
// low, code_unit/status/end_of_string show the oldest result; raise pop
// to take it. Each byte gives zero or one result.
// cfg_we/cfg_wdata write legacy_mode; write it only while the block is idle.
// A taken byte is stored in the input queue; the back end reads it there,
// and any result it gives is stored in the result queue for the ports.
// Throughput: one byte per cycle while the result queue has room, set by
// the back-end escape state machine; an IN_DEPTH queue parts front and back.
// When pop is held low, the OUT_DEPTH result queue fills, the back end
// stops, the input queue fills and full rises; no word is lost.
// Reset (rst, synchronous) empties both queues, returns the decoder to
// plain text and clears legacy_mode to 0.
module string_escape_decoder_core import sed_pkg::*; #(
  parameter int IN_DEPTH  = IN_DEPTH_DEF,
  parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  char_byte,
  input  logic        is_last,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] code_unit,
  output logic [1:0]  status,
  output logic        end_of_string
);

  sed_class_t  cls_in;
  sed_class_t  cls_q;
  logic        q_empty;
  logic        q_pop;
  logic        res_full;
  logic        res_push;
  sed_result_t res_in;
  sed_result_t res_out;

  sed_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .char_byte (char_byte),
    .is_last   (is_last),
    .cls       (cls_in)
  );

  sed_fifo #(
    .WIDTH ($bits(sed_class_t)),
    .DEPTH (IN_DEPTH)
  ) u_in_q (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (cls_in),
    .full    (full),
    .pop     (q_pop),
    .rd_data (cls_q),
    .empty   (q_empty)
  );

  sed_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cls      (cls_q),
    .in_valid (!q_empty),
    .take     (q_pop),
    .out_full (res_full),
    .res_push (res_push),
    .res      (res_in)
  );

  sed_fifo #(
    .WIDTH ($bits(sed_result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst     (rst),
    .push    (res_push),
    .wr_data (res_in),
    .full    (res_full),
    .pop     (pop),
    .rd_data (res_out),
    .empty   (empty)
  );

  assign code_unit     = res_out.code_unit;
  assign status        = res_out.status;
  assign end_of_string = res_out.end_of_string;

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result written into a full result queue");

  a_take_only_valid: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("back end took a word from an empty queue");

  a_error_ends_string: assert property (@(posedge clk) disable iff (rst)
    (res_push && (res_in.status == ST_ILLEGAL || res_in.status == ST_SHORT))
      |-> (res_in.end_of_string && res_in.code_unit == 16'd0))
    else $error("error result not marked as end of string");

endmodule
